// File: design/icaf_pkg.sv
// Package: constants, types and tables of the attitude filter.
package icaf_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 16;
  localparam int TAB_FRAC = 24;
  localparam int TAB_DEPTH = 24;
  localparam int ANG_W = 25;
  localparam int CFG_W = 17;
  localparam int CFG_IDX_W = 1;
  localparam int CW = 32;          // CORDIC vector width
  localparam int ZW = 36;          // CORDIC angle accumulator width
  localparam logic [12:0] PERIOD_RESET = 13'd655;
  localparam logic [16:0] WEIGHT_RESET = 17'd45875;
  localparam logic [16:0] WEIGHT_ONE = 17'd65536;
  localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;
  localparam logic signed [15:0] RATE_LIMIT = 16'sd32000;

  localparam logic CFG_PERIOD = 1'b0;
  localparam logic CFG_WEIGHT = 1'b1;

  typedef enum logic [1:0] {
    ST_UPDATED = 2'd0,
    ST_INIT = 2'd1,
    ST_RESET = 2'd2,
    ST_REJECT = 2'd3
  } status_t;

  typedef struct packed {
    logic       load;      // capture input word, start checks
    logic       pass_init; // load first CORDIC pass
    logic       step;      // one CORDIC iteration
    logic       mag_mul;   // scale magnitude by 1/K
    logic       pass2_init;
    logic       integ;     // gyro integration
    logic       blend_a;   // first blend product
    logic       blend_b;
    logic       commit;    // write state, present result
  } cmd_t;

  typedef struct packed {
    logic    reject;
    logic    is_reset;
    logic    seeded;
  } stat_t;

  function automatic logic [ZW-1:0] atan_entry(input logic [4:0] i);
    logic [ZW-1:0] r;
    case (i)
      5'd0: r = 36'd754974720;  5'd1: r = 36'd445687602;
      5'd2: r = 36'd235489088;  5'd3: r = 36'd119537938;
      5'd4: r = 36'd60000934;   5'd5: r = 36'd30029717;
      5'd6: r = 36'd15018523;   5'd7: r = 36'd7509720;
      5'd8: r = 36'd3754917;    5'd9: r = 36'd1877466;
      5'd10: r = 36'd938734;    5'd11: r = 36'd469367;
      5'd12: r = 36'd234684;    5'd13: r = 36'd117342;
      5'd14: r = 36'd58671;     5'd15: r = 36'd29335;
      5'd16: r = 36'd14668;     5'd17: r = 36'd7334;
      5'd18: r = 36'd3667;      5'd19: r = 36'd1833;
      5'd20: r = 36'd917;       5'd21: r = 36'd458;
      5'd22: r = 36'd229;       5'd23: r = 36'd115;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: design/icaf_if.sv
// Valid/ready channel interfaces for sample and result words.
interface icaf_in_if;
  logic valid;
  logic ready;
  logic func;
  logic signed [15:0] rate_x;
  logic signed [15:0] rate_y;
  logic signed [15:0] rate_z;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  modport source (output valid, func, rate_x, rate_y, rate_z, accel_x, accel_y, accel_z,
                  input ready);
  modport sink (input valid, func, rate_x, rate_y, rate_z, accel_x, accel_y, accel_z,
                output ready);
endinterface

interface icaf_out_if;
  logic valid;
  logic ready;
  logic [1:0] status;
  logic signed [24:0] roll_angle;
  logic signed [24:0] pitch_angle;
  logic signed [24:0] yaw_angle;
  modport source (output valid, status, roll_angle, pitch_angle, yaw_angle, input ready);
  modport sink (input valid, status, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

// File: design/icaf_ctrl.sv
// Sequencer of the attitude filter: walks checks, two CORDIC passes, update.
module icaf_ctrl
  import icaf_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam int NSTEP = (CORDIC_STEPS < TAB_DEPTH) ? CORDIC_STEPS : TAB_DEPTH;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_CHECK = 11'b00000000010,
    S_P1    = 11'b00000000100,
    S_MAG   = 11'b00000001000,
    S_P2I   = 11'b00000010000,
    S_P2    = 11'b00000100000,
    S_SAVE  = 11'b00001000000,
    S_INTEG = 11'b00010000000,
    S_BLA   = 11'b00100000000,
    S_BLB   = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_t;

  state_t state, state_next;
  logic [4:0] cnt, cnt_next;
  logic out_busy, out_busy_next;

  assign in_ready = (state == S_IDLE);
  assign out_valid = out_busy;

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    out_busy_next = out_busy;
    cmd = '0;
    if (out_busy && out_ready) out_busy_next = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.reject) begin
          state_next = S_DONE;
        end else begin
          cmd.pass_init = 1'b1;
          cnt_next = '0;
          state_next = S_P1;
        end
      end
      S_P1: begin
        cmd.step = 1'b1;
        cnt_next = cnt + 5'd1;
        if (cnt == 5'(NSTEP - 1)) state_next = S_MAG;
      end
      S_MAG: begin
        cmd.mag_mul = 1'b1;
        state_next = S_P2I;
      end
      S_P2I: begin
        cmd.pass2_init = 1'b1;
        cnt_next = '0;
        state_next = S_P2;
      end
      S_P2: begin
        cmd.step = 1'b1;
        cnt_next = cnt + 5'd1;
        if (cnt == 5'(NSTEP - 1)) state_next = S_SAVE;
      end
      S_SAVE: begin
        state_next = (!stat.is_reset && stat.seeded) ? S_INTEG : S_DONE;
      end
      S_INTEG: begin
        cmd.integ = 1'b1;
        state_next = S_BLA;
      end
      S_BLA: begin
        cmd.blend_a = 1'b1;
        state_next = S_BLB;
      end
      S_BLB: begin
        cmd.blend_b = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_busy) begin
          cmd.commit = 1'b1;
          out_busy_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      out_busy <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      out_busy <= out_busy_next;
    end
  end

`ifndef SYNTHESIS
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !out_busy) else $error("result overwritten");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_P1 || state == S_P2) |-> cnt < 5'(NSTEP)) else $error("step count");
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == S_CHECK) else $error("load sequencing");
`endif

endmodule

// File: design/icaf_dp.sv
// Datapath: sample checks, shared CORDIC unit, integration, blend, state.
module icaf_dp
  import icaf_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  cmd_t cmd,
  output stat_t stat,
  input  logic cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic func,
  input  logic signed [15:0] rate_x,
  input  logic signed [15:0] rate_y,
  input  logic signed [15:0] rate_z,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  output logic [1:0] status,
  output logic signed [ANG_W-1:0] roll_angle,
  output logic signed [ANG_W-1:0] pitch_angle,
  output logic signed [ANG_W-1:0] yaw_angle
);

  localparam int SH = TAB_FRAC - ANGLE_FRAC_BITS;
  localparam int GS = 20 - ANGLE_FRAC_BITS;
  localparam logic signed [ANG_W+1:0] HALF = 27'sd180 <<< ANGLE_FRAC_BITS;
  localparam logic signed [ZW-1:0] Z90 = 36'sd90 <<< TAB_FRAC;

  logic [12:0] period;
  logic [16:0] weight;
  logic is_reset, seeded, reject;
  logic signed [15:0] gx, gy, gz, ax, ay, az;
  logic signed [ANG_W-1:0] roll_est, pitch_est, yaw_est, roll_acc;
  logic signed [CW-1:0] cx, cy;
  logic signed [ZW-1:0] cz;
  logic [4:0] idx;
  logic [33:0] sq;
  logic signed [ANG_W-1:0] r_g, p_g, y_g;
  logic signed [42:0] br, bp;

  function automatic logic signed [ANG_W-1:0] wrap1(input logic signed [ANG_W+1:0] a);
    logic signed [ANG_W+1:0] r;
    r = a;
    if (a > HALF) r = a - (HALF <<< 1);
    else if (a < -HALF) r = a + (HALF <<< 1);
    return r[ANG_W-1:0];
  endfunction

  function automatic logic signed [ANG_W-1:0] to_ang(input logic signed [ZW-1:0] z);
    logic signed [ZW-1:0] t;
    t = (z + (ZW'(1) <<< (SH - 1))) >>> SH;
    return wrap1(t[ANG_W+1:0]);
  endfunction

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      period <= PERIOD_RESET;
      weight <= WEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PERIOD: period <= cfg_data[12:0];
        CFG_WEIGHT: weight <= cfg_data;
        default: ;
      endcase
    end
  end

  // check and CORDIC vector setup
  logic signed [CW-1:0] p1x, p1y, p2y;
  logic signed [CW-1:0] ix, iy;
  logic signed [ZW-1:0] iz;
  logic signed [CW-1:0] dx, dy;
  logic rate_bad;
  logic [63:0] magp;
  logic signed [CW-1:0] mag_q;

  always_comb begin
    p1x = -(CW'(az) <<< 8);
    p1y = CW'(ay) <<< 8;
    p2y = -(CW'(ax) <<< 8);
    rate_bad = (gx > RATE_LIMIT) || (gx < -RATE_LIMIT) || (gy > RATE_LIMIT) ||
               (gy < -RATE_LIMIT) || (gz > RATE_LIMIT) || (gz < -RATE_LIMIT);
    reject = (34'(sq) * 34'd100 < 34'(1 << 24)) || (sq > 34'(1 << 26)) ||
             (!is_reset && rate_bad);
    ix = cmd.pass_init ? p1x : mag_q;
    iy = cmd.pass_init ? p1y : p2y;
    iz = '0;
    if (ix < 0) begin
      if (iy >= 0) begin
        iz = Z90;
        {ix, iy} = {iy, -ix};
      end else begin
        iz = -Z90;
        {ix, iy} = {-iy, ix};
      end
    end
    dx = cx >>> idx;
    dy = cy >>> idx;
  end

  assign stat = '{reject: reject, is_reset: is_reset, seeded: seeded};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      is_reset <= func;
      gx <= rate_x; gy <= rate_y; gz <= rate_z;
      ax <= accel_x; ay <= accel_y; az <= accel_z;
    end
  end

  // magnitude square of the input accel word, registered at load for the check state
  always_ff @(posedge clk) begin
    if (cmd.load)
      sq <= 34'(32'(accel_x * accel_x)) + 34'(32'(accel_y * accel_y))
            + 34'(32'(accel_z * accel_z));
  end

  always_ff @(posedge clk) begin
    if (cmd.pass_init || cmd.pass2_init) begin
      cx <= ix; cy <= iy; cz <= iz; idx <= '0;
    end else if (cmd.step) begin
      // zero vector stays zero and never steps the angle
      if (!(cx == 0 && cy == 0)) begin
        if (cy >= 0) begin
          cx <= cx + dy; cy <= cy - dx; cz <= cz + $signed(atan_entry(idx));
        end else begin
          cx <= cx - dy; cy <= cy + dx; cz <= cz - $signed(atan_entry(idx));
        end
      end
      idx <= idx + 5'd1;
    end
    if (cmd.mag_mul) begin
      roll_acc <= to_ang(cz);
      magp <= (cx < 0 ? 64'd0 : 64'(cx)) * 64'(INV_GAIN_Q30);
    end
  end

  assign mag_q = CW'((magp + (64'd1 << 29)) >> 30);

  // state update
  logic signed [ANG_W+1:0] r_s, p_s, y_s;
  logic signed [CW-1:0] dt;
  logic [16:0] w;
  always_comb begin
    w = (weight > WEIGHT_ONE) ? WEIGHT_ONE : weight;
    dt = CW'($signed({1'b0, period}));
    r_s = 27'(roll_est) + 27'(((32'(gx) * dt) + (32'(1) <<< GS) / 2) >>> GS);
    p_s = 27'(pitch_est) + 27'(((32'(gy) * dt) + (32'(1) <<< GS) / 2) >>> GS);
    y_s = 27'(yaw_est) + 27'(((32'(gz) * dt) + (32'(1) <<< GS) / 2) >>> GS);
  end

  always_ff @(posedge clk) begin
    if (cmd.integ) begin
      r_g <= wrap1(r_s); p_g <= wrap1(p_s); y_g <= wrap1(y_s);
    end
    if (cmd.blend_a) begin
      br <= 43'($signed({1'b0, w})) * 43'(r_g);
      bp <= 43'($signed({1'b0, w})) * 43'(p_g);
    end
    if (cmd.blend_b) begin
      br <= (br + 43'($signed({1'b0, WEIGHT_ONE - w})) * 43'(roll_acc) + 43'sd32768) >>> 16;
      bp <= (bp + 43'($signed({1'b0, WEIGHT_ONE - w})) * 43'(to_ang(cz)) + 43'sd32768)
            >>> 16;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      roll_est <= '0; pitch_est <= '0; yaw_est <= '0; seeded <= 1'b0;
      status <= ST_UPDATED;
    end else if (cmd.commit) begin
      if (reject) begin
        status <= ST_REJECT;
      end else if (is_reset || !seeded) begin
        roll_est <= roll_acc; pitch_est <= to_ang(cz); yaw_est <= '0;
        status <= is_reset ? ST_RESET : ST_INIT;
        if (!is_reset) seeded <= 1'b1;
      end else begin
        roll_est <= br[ANG_W-1:0]; pitch_est <= bp[ANG_W-1:0]; yaw_est <= y_g;
        status <= ST_UPDATED;
      end
    end
  end

  assign roll_angle = roll_est;
  assign pitch_angle = pitch_est;
  assign yaw_angle = yaw_est;

`ifndef SYNTHESIS
  a_wrap: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.commit) |-> (roll_est <= HALF[ANG_W-1:0] || roll_est[ANG_W-1]))
    else $error("roll out of range");
  a_yaw_seed: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && !reject && (is_reset || !seeded)) |=> yaw_est == '0)
    else $error("yaw not cleared on seed");
  a_reject_hold: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && reject) |=> $stable(roll_est) && $stable(yaw_est))
    else $error("rejected sample changed state");
`endif

endmodule

// File: design/imu_complementary_attitude_filter.sv
// Top level: roll/pitch/yaw complementary filter with config write port.
// From sample accept to result valid: check; for a seed or angle reset two CORDIC passes
// of N = min(CORDIC_STEPS,24) steps each, then commit; for an update also integrate and
// blend; a rejected sample goes from check to commit. The shared CORDIC does one step a cycle.
// One sample in work at a time: next accept in the cycle after the result is
// committed; commit waits while the last result is unread.
// Reset (rst, synchronous) clears angles and seeded flag and loads config defaults.
module imu_complementary_attitude_filter
  import icaf_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input logic clk,
  input logic rst,
  icaf_in_if.sink in_ch,
  icaf_out_if.source out_ch,
  input logic cfg_we,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [CFG_W-1:0] cfg_data
);

  cmd_t cmd;
  stat_t stat;

  icaf_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .stat, .cmd
  );

  icaf_dp #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_dp (
    .clk, .rst, .cmd, .stat,
    .cfg_we, .cfg_index, .cfg_data,
    .func(in_ch.func), .rate_x(in_ch.rate_x), .rate_y(in_ch.rate_y),
    .rate_z(in_ch.rate_z), .accel_x(in_ch.accel_x), .accel_y(in_ch.accel_y),
    .accel_z(in_ch.accel_z),
    .status(out_ch.status), .roll_angle(out_ch.roll_angle),
    .pitch_angle(out_ch.pitch_angle), .yaw_angle(out_ch.yaw_angle)
  );

endmodule

// File: tb/icaf_tb_if.sv
// Testbench bundle of the config write port.
interface icaf_cfg_if;
  logic        we;
  logic [0:0]  index;
  logic [16:0] data;
endinterface

// File: tb/imu_complementary_attitude_filter_tb.sv
// Testbench for the attitude filter: directed and random samples, predicted results checked.
module imu_complementary_attitude_filter_tb;
  import icaf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint HALF = 64'sd180 <<< 16;
  localparam int LIMIT = 400000;

  typedef struct {
    logic [1:0] status;
    longint roll;
    longint pitch;
    longint yaw;
  } attitude_t;

  logic clk, rst;
  icaf_in_if in_ch();
  icaf_out_if out_ch();
  icaf_cfg_if cfg();

  imu_complementary_attitude_filter u_top (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg.we), .cfg_index(cfg.index), .cfg_data(cfg.data)
  );

  // predictor state
  longint roll_q, pitch_q, yaw_q;
  bit seeded_q;
  longint period_q, weight_q;
  attitude_t expected_q[$];
  int errors;
  int cycles;
  int burst_left;

  function automatic longint asr(longint v, int s);
    return v < 0 ? -1 - ((-1 - v) >>> s) : v >>> s;
  endfunction

  function automatic longint rnd_shift(longint v, int s);
    if (s == 0) return v;
    return asr(v + (64'sd1 <<< (s - 1)), s);
  endfunction

  function automatic longint wrap_turn(longint a);
    if (a > HALF) return a - 2 * HALF;
    if (a < -HALF) return a + 2 * HALF;
    return a;
  endfunction

  function automatic longint atan_val(int i);
    longint t[24] = '{754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
                      15018523, 7509720, 3754917, 1877466, 938734, 469367,
                      234684, 117342, 58671, 29335, 14668, 7334,
                      3667, 1833, 917, 458, 229, 115};
    return t[i];
  endfunction

  // vectoring rotation: angle in 2^-24 deg, gain-scaled magnitude out
  function automatic longint vec_angle(longint x, longint y, output longint mag);
    longint z, t, dx, dy;
    z = 0;
    if (x == 0 && y == 0) begin
      mag = 0;
      return 0;
    end
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = 64'sd90 <<< 24;
      end else begin
        t = x; x = -y; y = t; z = -(64'sd90 <<< 24);
      end
    end
    for (int i = 0; i < 16; i++) begin
      dx = asr(x, i);
      dy = asr(y, i);
      if (y >= 0) begin
        x += dy; y -= dx; z += atan_val(i);
      end else begin
        x -= dy; y += dx; z -= atan_val(i);
      end
    end
    mag = x;
    return z;
  endfunction

  function automatic attitude_t predict_attitude(bit fn, longint gx, gy, gz, ax, ay, az);
    attitude_t res;
    longint sq, mag, m2, zr, zp, ar, ap, r, p, w;
    bit ok;
    sq = ax * ax + ay * ay + az * az;
    ok = (100 * sq >= (64'sd1 <<< 24)) && (sq <= (64'sd1 <<< 26));
    if (!fn && (gx > 32000 || gx < -32000 || gy > 32000 || gy < -32000 ||
                gz > 32000 || gz < -32000)) ok = 0;
    if (!ok) begin
      res.status = ST_REJECT;
    end else begin
      zr = vec_angle(-az * 256, ay * 256, mag);
      if (mag < 0) mag = 0;
      mag = (mag * 652032874 + (64'sd1 <<< 29)) >>> 30;
      zp = vec_angle(mag, -ax * 256, m2);
      ar = wrap_turn(rnd_shift(zr, 8));
      ap = wrap_turn(rnd_shift(zp, 8));
      if (fn || !seeded_q) begin
        roll_q = ar; pitch_q = ap; yaw_q = 0;
        res.status = fn ? ST_RESET : ST_INIT;
        if (!fn) seeded_q = 1;
      end else begin
        w = weight_q > 65536 ? 65536 : weight_q;
        r = wrap_turn(roll_q + rnd_shift(gx * period_q, 4));
        p = wrap_turn(pitch_q + rnd_shift(gy * period_q, 4));
        yaw_q = wrap_turn(yaw_q + rnd_shift(gz * period_q, 4));
        roll_q = asr(w * r + (65536 - w) * ar + 32768, 16);
        pitch_q = asr(w * p + (65536 - w) * ap + 32768, 16);
        res.status = ST_UPDATED;
      end
    end
    res.roll = roll_q; res.pitch = pitch_q; res.yaw = yaw_q;
    return res;
  endfunction

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // receiver stalls on its own pattern
  initial begin
    out_ch.ready = 0;
    forever begin
      @(posedge clk);
      if (cycles % 300 < 100) out_ch.ready <= 1;
      else out_ch.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // result checker
  always @(posedge clk) begin
    attitude_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_ch.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_ch.status); errors++;
        end
        if (out_ch.roll_angle !== e.roll[24:0]) begin
          $error("roll_angle exp %0d got %0d", e.roll, out_ch.roll_angle); errors++;
        end
        if (out_ch.pitch_angle !== e.pitch[24:0]) begin
          $error("pitch_angle exp %0d got %0d", e.pitch, out_ch.pitch_angle); errors++;
        end
        if (out_ch.yaw_angle !== e.yaw[24:0]) begin
          $error("yaw_angle exp %0d got %0d", e.yaw, out_ch.yaw_angle); errors++;
        end
      end
    end
  end

  task automatic send_sample(bit fn, logic [15:0] gx, gy, gz, ax, ay, az);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      repeat ($urandom_range(0, 60)) @(posedge clk);
    end
    burst_left--;
    in_ch.valid <= 1;
    in_ch.func <= fn;
    in_ch.rate_x <= gx; in_ch.rate_y <= gy; in_ch.rate_z <= gz;
    in_ch.accel_x <= ax; in_ch.accel_y <= ay; in_ch.accel_z <= az;
    do @(posedge clk); while (!in_ch.ready);
    expected_q.push_back(predict_attitude(fn, $signed(gx), $signed(gy), $signed(gz),
                                          $signed(ax), $signed(ay), $signed(az)));
    in_ch.valid <= 0;
    // the block takes no new sample until the current result is committed anyway
    @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    cfg.we <= 1; cfg.index <= idx; cfg.data <= val;
    @(posedge clk);
    cfg.we <= 0;
    if (idx == CFG_PERIOD) period_q = val[12:0];
    else weight_q = val;
  endtask

  task automatic random_level(output logic [15:0] ax, ay, az);
    // mostly plausible gravity vectors, some raw noise
    if ($urandom_range(0, 9) == 0) begin
      ax = 16'($urandom); ay = 16'($urandom); az = 16'($urandom);
    end else begin
      ax = 16'($urandom_range(0, 8000) - 4000);
      ay = 16'($urandom_range(0, 8000) - 4000);
      az = 16'($urandom_range(0, 8000) - 4000);
    end
  endtask

  task automatic test_directed();
    send_sample(1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0); // zero accel rejected
    send_sample(1'b0, 16'sd100, -16'sd50, 16'sd30, 16'sd0, 16'sd0, -16'sd4096); // seeds
    send_sample(1'b0, 16'sd32000, -16'sd32000, 16'sd32000, 16'sd0, 16'sd0, 16'sd4096);
    send_sample(1'b0, 16'sd32001, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd4096); // rate limit
    send_sample(1'b0, 16'sd0, -16'sd32001, 16'sd0, 16'sd0, 16'sd0, 16'sd4096);
    send_sample(1'b0, 16'sd0, 16'sd0, 16'h8000, 16'sd0, 16'sd0, 16'sd4096);
    send_sample(1'b1, 16'h8000, 16'h7fff, 16'h8000, 16'sd4096, 16'sd0, 16'sd0); // rates ignored
    send_sample(1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd410, 16'sd0, 16'sd0); // just above floor
    send_sample(1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd409, 16'sd0, 16'sd0); // below floor
    send_sample(1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd8192); // exactly 4 g^2
    send_sample(1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd8193);
    send_sample(1'b0, 16'sd0, 16'sd0, 16'sd0, 16'h8000, 16'h8000, 16'h8000);
    send_sample(1'b0, 16'h7fff, 16'sd0, 16'sd0, 16'sd0, 16'sd4096, 16'sd0); // x at zero
    send_sample(1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd4096, 16'sd10); // roll near -90
    send_sample(1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd4096, 16'sd10);
    send_sample(1'b0, 16'sd32000, 16'sd32000, 16'sd32000, -16'sd4096, 16'sd0, 16'sd0);
    send_sample(1'b1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0); // rejected reset
    send_sample(1'b0, 16'sd1234, 16'sd0, 16'sd0, 16'sd0, 16'sd2896, -16'sd2896);
  endtask

  task automatic test_random(int count);
    logic [15:0] ax, ay, az;
    logic [15:0] gx, gy, gz;
    for (int i = 0; i < count; i++) begin
      random_level(ax, ay, az);
      if ($urandom_range(0, 15) == 0) begin
        gx = 16'($urandom); gy = 16'($urandom); gz = 16'($urandom);
      end else begin
        gx = 16'($urandom_range(0, 64000) - 32000);
        gy = 16'($urandom_range(0, 64000) - 32000);
        gz = 16'($urandom_range(0, 64000) - 32000);
      end
      send_sample($urandom_range(0, 19) == 0, gx, gy, gz, ax, ay, az);
    end
  endtask

  task automatic test_settings();
    write_reg(CFG_PERIOD, 17'd6553); write_reg(CFG_WEIGHT, WEIGHT_ONE);
    test_random(120);
    write_reg(CFG_PERIOD, 17'd1); write_reg(CFG_WEIGHT, 17'd0);
    test_random(120);
    write_reg(CFG_PERIOD, 17'd0); write_reg(CFG_WEIGHT, 17'h1ffff); // saturating alpha
    test_random(100);
    write_reg(CFG_PERIOD, 17'h1fff); write_reg(CFG_WEIGHT, 17'd32768);
    test_random(120);
    write_reg(CFG_PERIOD, CFG_W'($urandom_range(1, 6553)));
    write_reg(CFG_WEIGHT, CFG_W'($urandom_range(0, 65536)));
    test_random(150);
  endtask

  initial begin
    errors = 0;
    burst_left = 0;
    roll_q = 0; pitch_q = 0; yaw_q = 0; seeded_q = 0;
    period_q = 655; weight_q = 45875;
    rst = 1;
    cfg.we = 0; cfg.index = '0; cfg.data = '0;
    in_ch.valid = 0; in_ch.func = 0;
    in_ch.rate_x = 0; in_ch.rate_y = 0; in_ch.rate_z = 0;
    in_ch.accel_x = 0; in_ch.accel_y = 0; in_ch.accel_z = 0;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_random(130);
    test_settings();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
